FILE: hw/rtl/bcvm_pkg.sv
// Shared types, constants and helper functions of the boot chain verifier.
// No dependencies; every other file of the block refers to this package.
package bcvm_pkg;

   // request modes
   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_END   = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   // configuration register indexes
   localparam logic CSR_SIGNING_KEY  = 1'b0;
   localparam logic CSR_INITIAL_MEAS = 1'b1;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] KEY_RESET = 64'hA5A5F00DDEADBEEF;

   // stage and boot counters saturate at the lesser of MAX_STAGES and 255
   localparam int MAX_STAGES = 255;
   localparam logic [7:0] COUNT_CAP = 8'((MAX_STAGES < 255) ? MAX_STAGES : 255);

   // extension folds eight bytes of the old measurement and eight of the hash
   localparam int EXT_ROUNDS = 16;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  code_byte;
      logic [63:0] expected_signature;
   } req_type;

   typedef struct packed {
      logic [7:0]  stage_index;
      logic        stage_reached;
      logic        stage_pass;
      logic [63:0] measurement_value;
      logic [7:0]  stages_booted;
      logic        chain_halted;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic fold_byte;
      logic start_chain;
      logic stage_end;
      logic rsp_now;
      logic ext_step;
      logic ext_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sig_match;
      logic halted;
   } status_type;

   // FNV-1a step; multiply by 2^40 + 0x1b3 done as shift-add
   function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v < COUNT_CAP) ? v + 8'd1 : COUNT_CAP;
   endfunction

endpackage

FILE: hw/rtl/boot_chain_verify_and_measure.sv
// Top level of the boot chain verifier with measured boot.
// Instantiates bcvm_ctrl and bcvm_dp; types and constants from bcvm_pkg.
//
// Code-byte requests (mode 0) fold one byte into a 64-bit FNV-1a image hash
// and are taken one per cycle while no extension runs; start-chain requests
// (mode 2) and the unused mode 3 give no result. An end-of-stage request
// (mode 1) checks (hash ^ signing_key) against the expected signature and
// gives one result. A failed stage, or any stage after the chain halted, is
// answered straight from the accept cycle. A passing stage goes on from the
// accept cycle into 16 rounds of the single shared FNV fold unit that extend
// the measurement register over its old eight bytes and the eight hash
// bytes, low byte first. Results sit in an output register; code bytes keep
// flowing while a result waits, and only the next end-of-stage request
// stalls until the result register is free. Configuration writes (index 0
// signing key, index 1 initial measurement) take effect at once and are
// meant for idle periods. The initial measurement is loaded by a start-chain
// request; after reset the measurement register is zero.
module boot_chain_verify_and_measure (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  bcvm_pkg::req_type  req_data,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bcvm_pkg::rsp_type  rsp_data,
   // configuration writes
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [63:0]        csr_write_data
);

   bcvm_pkg::cmd_type    cmd;
   bcvm_pkg::status_type status;

   // sequencing: handshake, extension round counter, result valid
   bcvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hash, measurement, counters, config registers, result payload
   bcvm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

FILE: hw/rtl/bcvm_ctrl.sv
// Controller of the boot chain verifier: request handshake, extension
// sequencing and result valid. Depends on bcvm_pkg.
module bcvm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_mode,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bcvm_pkg::status_type  status,
   output bcvm_pkg::cmd_type     cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_EXTEND = 1'b1;
   localparam int   RW        = $clog2(bcvm_pkg::EXT_ROUNDS);
   localparam logic [RW-1:0] ROUND_LAST = RW'(bcvm_pkg::EXT_ROUNDS - 1);

   logic          state_ff, state_in;
   logic [RW-1:0] round_ff, round_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      // only an end-of-stage request needs the result register free
      req_ready    = (state_ff == ST_IDLE) &&
                     (req_mode != bcvm_pkg::MODE_END || !rsp_valid_ff || rsp_ready);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_mode)
                  bcvm_pkg::MODE_BYTE: begin
                     cmd.fold_byte = 1'b1;
                  end
                  bcvm_pkg::MODE_END: begin
                     cmd.stage_end = 1'b1;
                     if (!status.halted && status.sig_match) begin
                        state_in = ST_EXTEND;
                        round_in = '0;
                     end else begin
                        cmd.rsp_now  = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  bcvm_pkg::MODE_START: begin
                     cmd.start_chain = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXTEND: begin
            cmd.ext_step = 1'b1;
            round_in     = round_ff + RW'(1);
            if (round_ff == ROUND_LAST) begin
               cmd.ext_last = 1'b1;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/bcvm_dp.sv
// Datapath of the boot chain verifier: hash, measurement, counters, config
// registers, shared FNV fold unit and result register. Depends on bcvm_pkg.
module bcvm_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  bcvm_pkg::req_type     req_data,
   input  bcvm_pkg::cmd_type     cmd,
   output bcvm_pkg::status_type  status,
   output bcvm_pkg::rsp_type     rsp_data,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [63:0]           csr_write_data
);

   logic [63:0]  key_ff, key_in;
   logic [63:0]  init_ff, init_in;
   logic [63:0]  hash_ff, hash_in;
   logic [63:0]  meas_ff, meas_in;
   logic [7:0]   booted_ff, booted_in;
   logic [7:0]   stage_ff, stage_in;
   logic         halted_ff, halted_in;
   logic [63:0]  ext_hash_ff, ext_hash_in;
   logic [127:0] ext_bytes_ff, ext_bytes_in;
   logic [7:0]   idx_hold_ff, idx_hold_in;
   bcvm_pkg::rsp_type rsp_ff, rsp_in;

   logic [63:0]  fold_h, fold_out;
   logic [7:0]   fold_b;

   // one fold unit: image bytes when idle, extension bytes otherwise
   assign fold_h   = cmd.ext_step ? ext_hash_ff : hash_ff;
   assign fold_b   = cmd.ext_step ? ext_bytes_ff[7:0] : req_data.code_byte;
   assign fold_out = bcvm_pkg::fnv_fold(fold_h, fold_b);

   assign status.sig_match = ((hash_ff ^ key_ff) == req_data.expected_signature);
   assign status.halted    = halted_ff;

   always_comb begin
      key_in       = key_ff;
      init_in      = init_ff;
      hash_in      = hash_ff;
      meas_in      = meas_ff;
      booted_in    = booted_ff;
      stage_in     = stage_ff;
      halted_in    = halted_ff;
      ext_hash_in  = ext_hash_ff;
      ext_bytes_in = ext_bytes_ff;
      idx_hold_in  = idx_hold_ff;
      rsp_in       = rsp_ff;

      if (csr_write_enable) begin
         case (csr_index)
            bcvm_pkg::CSR_SIGNING_KEY:  key_in  = csr_write_data;
            bcvm_pkg::CSR_INITIAL_MEAS: init_in = csr_write_data;
            default: begin
            end
         endcase
      end

      if (cmd.fold_byte) begin
         hash_in = fold_out;
      end

      if (cmd.start_chain) begin
         hash_in   = bcvm_pkg::FNV_BASIS;
         meas_in   = init_ff;
         booted_in = '0;
         stage_in  = '0;
         halted_in = 1'b0;
      end

      if (cmd.stage_end) begin
         idx_hold_in  = stage_ff;
         stage_in     = bcvm_pkg::sat_inc(stage_ff);
         hash_in      = bcvm_pkg::FNV_BASIS;
         ext_hash_in  = bcvm_pkg::FNV_BASIS;
         // old measurement bytes first, low byte first, then the hash
         ext_bytes_in = {hash_ff, meas_ff};
         if (!halted_ff) begin
            if (status.sig_match) begin
               booted_in = bcvm_pkg::sat_inc(booted_ff);
            end else begin
               halted_in = 1'b1;
            end
         end
      end

      // failed or unreached stage: result right away
      if (cmd.rsp_now) begin
         rsp_in.stage_index       = stage_ff;
         rsp_in.stage_reached     = !halted_ff;
         rsp_in.stage_pass        = 1'b0;
         rsp_in.measurement_value = meas_ff;
         rsp_in.stages_booted     = booted_ff;
         rsp_in.chain_halted      = 1'b1;
      end

      if (cmd.ext_step) begin
         ext_hash_in  = fold_out;
         ext_bytes_in = ext_bytes_ff >> 8;
      end

      if (cmd.ext_last) begin
         meas_in                  = fold_out;
         rsp_in.stage_index       = idx_hold_ff;
         rsp_in.stage_reached     = 1'b1;
         rsp_in.stage_pass        = 1'b1;
         rsp_in.measurement_value = fold_out;
         rsp_in.stages_booted     = booted_ff;
         rsp_in.chain_halted      = halted_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= bcvm_pkg::KEY_RESET;
         init_ff   <= '0;
         hash_ff   <= bcvm_pkg::FNV_BASIS;
         meas_ff   <= '0;
         booted_ff <= '0;
         stage_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         key_ff    <= key_in;
         init_ff   <= init_in;
         hash_ff   <= hash_in;
         meas_ff   <= meas_in;
         booted_ff <= booted_in;
         stage_ff  <= stage_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      ext_hash_ff  <= ext_hash_in;
      ext_bytes_ff <= ext_bytes_in;
      idx_hold_ff  <= idx_hold_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/bcvm_checker.sv
// Port-level assertions for the boot chain verifier, bound to the top level.
// Depends on bcvm_pkg and boot_chain_verify_and_measure.
module bcvm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input bcvm_pkg::req_type  req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input bcvm_pkg::rsp_type  rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an end-of-stage request waits while the result register is occupied
   a_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_data.mode == bcvm_pkg::MODE_END && rsp_valid && !rsp_ready
      |-> !req_ready)
      else $error("end-of-stage request taken over a waiting result");

   a_pass_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stage_pass |-> rsp_data.stage_reached && !rsp_data.chain_halted)
      else $error("passing stage with inconsistent flags");

   a_fail_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stage_pass |-> rsp_data.chain_halted)
      else $error("failed or unreached stage without halt");

endmodule

bind boot_chain_verify_and_measure bcvm_checker u_bcvm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
